// ===== rtl/tts_pkg.sv =====
// Shared types and constants for the tournament tree sorter.
// No dependencies; the interfaces, front end, queue, engine and top refer to it by scoped names.
package tts_pkg;

	localparam int VALUE_W       = 64;
	localparam int DEF_MAX_ITEMS = 64;
	localparam int QUEUE_AW      = 1;
	localparam int QUEUE_DEPTH   = 2 ** QUEUE_AW;

	localparam logic signed [VALUE_W-1:0] TOP_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};

	// one classified item on its way from the front to the back
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      close;
	} tts_entry_t;

endpackage

// ===== rtl/tts_if.sv =====
// Valid/ready channel interfaces for the sorter's input and result items.
// Depends on tts_pkg for the value width.
interface tts_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [tts_pkg::VALUE_W-1:0] value;
	logic                               last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface tts_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [tts_pkg::VALUE_W-1:0] sorted_value;
	logic                               last_res;

	modport source (output valid, output sorted_value, output last_res, input ready);
	modport sink (input valid, input sorted_value, input last_res, output ready);
endinterface

// ===== rtl/tts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tts_front.sv =====
// Front end: accepts input items, counts the set and marks the item that closes it.
// Depends on tts_pkg and tts_if.
module tts_front #(
	parameter int MAX_ITEMS = tts_pkg::DEF_MAX_ITEMS
) (
	input  logic                clk,
	input  logic                arst_n,
	tts_in_if.sink              items,
	output logic                push_valid,
	input  logic                push_ready,
	output tts_pkg::tts_entry_t push_entry
);

	localparam int CNT_W = $clog2(MAX_ITEMS);

	logic [CNT_W-1:0] item_count_q;
	logic             close;

	// a full set closes even without the last flag
	assign close = items.last || (item_count_q == CNT_W'(MAX_ITEMS - 1));

	assign items.ready       = push_ready;
	assign push_valid        = items.valid;
	assign push_entry.value  = items.value;
	assign push_entry.close  = close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
		end else if (items.valid && push_ready) begin
			item_count_q <= close ? '0 : item_count_q + 1'b1;
		end
	end

endmodule

// ===== rtl/tts_queue.sv =====
// Short FIFO that decouples the front end from the sort engine.
// Depends on tts_pkg.
module tts_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  tts_pkg::tts_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output tts_pkg::tts_entry_t pop_entry
);

	localparam int AW = tts_pkg::QUEUE_AW;

	tts_pkg::tts_entry_t entries_q [tts_pkg::QUEUE_DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [AW:0]         cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != (AW+1)'(tts_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/tts_back.sv =====
// Sort engine: loads leaves, pads, plays the winner tree, then emits and replays.
// Depends on tts_pkg, tts_if and tts_ram (tree storage).
module tts_back #(
	parameter int MAX_ITEMS = tts_pkg::DEF_MAX_ITEMS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  tts_pkg::tts_entry_t pop_entry,
	tts_out_if.source           results
);

	localparam int LOG   = $clog2(MAX_ITEMS);
	localparam int K     = 2 ** LOG;
	localparam int NODES = 2 * K - 1;
	localparam int AW    = LOG + 1;
	localparam int VW    = tts_pkg::VALUE_W;

	typedef struct packed {
		logic [LOG-1:0]       idx;
		logic signed [VW-1:0] val;
	} node_t;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_BUILD = 6'b000100,
		ST_EMIT  = 6'b001000,
		ST_REP0  = 6'b010000,
		ST_REP   = 6'b100000
	} state_t;

	state_t         state_q;
	logic [LOG:0]   lp_q;
	logic [LOG:0]   n_q;
	logic [LOG:0]   emit_cnt_q;
	logic [AW-1:0]  ra_q;
	logic [AW-1:0]  ra_s1;
	logic           rd_v_s1;
	node_t          right_q;
	node_t          root_q;
	logic [AW-1:0]  cur_q;
	node_t          cur_val_q;
	logic           out_v_q;
	logic [VW-1:0]  out_val_q;
	logic           out_last_q;

	logic           we;
	logic [AW-1:0]  waddr;
	node_t          wdata;
	logic [AW-1:0]  raddr;
	node_t          rdata;
	logic [$bits(node_t)-1:0] rdata_raw;

	logic [AW-1:0]  leaf_addr;
	logic [AW-1:0]  root_leaf;
	logic [AW-1:0]  parent;
	logic [AW-1:0]  parent_sib;
	logic [AW-1:0]  leaf_sib;
	node_t          build_win;
	node_t          rep_win;
	logic [LOG:0]   lp_next;
	logic           emit_last;
	logic           emit_go;

	tts_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (NODES)
	) u_tree (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign rdata = node_t'(rdata_raw);

	assign leaf_addr  = AW'(K - 1) + AW'(lp_q[LOG-1:0]);
	assign root_leaf  = AW'(K - 1) + AW'(root_q.idx);
	assign leaf_sib   = root_leaf[0] ? root_leaf + 1'b1 : root_leaf - 1'b1;
	assign parent     = (cur_q - 1'b1) >> 1;
	assign parent_sib = parent[0] ? parent + 1'b1 : parent - 1'b1;
	assign lp_next    = lp_q + 1'b1;
	assign emit_last  = ((emit_cnt_q + 1'b1) == n_q);
	assign emit_go    = (state_q == ST_EMIT) && (!out_v_q || results.ready);

	// left child wins a tie
	assign build_win = ($signed(right_q.val) < $signed(rdata.val)) ? right_q : rdata;
	always_comb begin
		if (cur_q[0]) begin
			rep_win = ($signed(rdata.val) < $signed(cur_val_q.val)) ? rdata : cur_val_q;
		end else begin
			rep_win = ($signed(cur_val_q.val) < $signed(rdata.val)) ? cur_val_q : rdata;
		end
	end

	assign pop_ready = (state_q == ST_LOAD);

	always_comb begin
		we    = 1'b0;
		waddr = leaf_addr;
		wdata = '{idx: lp_q[LOG-1:0], val: pop_entry.value};
		raddr = ra_q;
		case (state_q)
			ST_LOAD: begin
				we = pop_valid;
			end
			ST_PAD: begin
				we    = 1'b1;
				wdata = '{idx: lp_q[LOG-1:0], val: tts_pkg::TOP_VALUE};
			end
			ST_BUILD: begin
				// odd address returning means both children are in hand
				we    = rd_v_s1 && ra_s1[0];
				waddr = ra_s1 >> 1;
				wdata = build_win;
			end
			ST_REP0: begin
				we    = 1'b1;
				waddr = root_leaf;
				wdata = '{idx: root_q.idx, val: tts_pkg::TOP_VALUE};
				raddr = leaf_sib;
			end
			ST_REP: begin
				we    = 1'b1;
				waddr = parent;
				wdata = rep_win;
				raddr = parent_sib;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ra_s1 <= ra_q;
		if (state_q == ST_BUILD && rd_v_s1 && !ra_s1[0]) begin
			right_q <= rdata;
		end
		if (state_q == ST_BUILD && rd_v_s1 && ra_s1[0] && (ra_s1 >> 1) == '0) begin
			root_q <= build_win;
		end else if (state_q == ST_REP && parent == '0) begin
			root_q <= rep_win;
		end
		if (state_q == ST_REP0) begin
			cur_q     <= root_leaf;
			cur_val_q <= '{idx: root_q.idx, val: tts_pkg::TOP_VALUE};
		end else if (state_q == ST_REP) begin
			cur_q     <= parent;
			cur_val_q <= rep_win;
		end
		if (emit_go) begin
			out_val_q  <= root_q.val;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			lp_q       <= '0;
			n_q        <= '0;
			emit_cnt_q <= '0;
			ra_q       <= '0;
			rd_v_s1    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (emit_go) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			rd_v_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (pop_valid) begin
						lp_q <= lp_next;
						if (pop_entry.close) begin
							n_q <= lp_next;
							ra_q <= AW'(NODES - 1);
							state_q <= (lp_next == (LOG+1)'(K)) ? ST_BUILD : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					lp_q <= lp_next;
					if (lp_next == (LOG+1)'(K)) begin
						state_q <= ST_BUILD;
					end
				end
				ST_BUILD: begin
					ra_q    <= ra_q - 1'b1;
					rd_v_s1 <= 1'b1;
					if (rd_v_s1 && ra_s1[0] && (ra_s1 >> 1) == '0) begin
						rd_v_s1 <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (emit_last) begin
							emit_cnt_q <= '0;
							lp_q       <= '0;
							state_q    <= ST_LOAD;
						end else begin
							emit_cnt_q <= emit_cnt_q + 1'b1;
							state_q    <= ST_REP0;
						end
					end
				end
				ST_REP0: begin
					state_q <= ST_REP;
				end
				ST_REP: begin
					if (parent == '0) begin
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign results.valid        = out_v_q;
	assign results.sorted_value = out_val_q;
	assign results.last_res     = out_last_q;

endmodule

// ===== rtl/tournament_tree_sorter_top.sv =====
// Tournament tree sorter: sorts sets of up to MAX_ITEMS signed 64-bit values.
// Depends on tts_pkg, tts_if, tts_front, tts_queue, tts_back and tts_ram.
//
// items carries one value per item; last marks the end of a set, and the
// MAX_ITEMS-th value of a set closes it on its own. results returns the set in
// ascending order, last_res on the final value. Both are valid/ready channels.
// Let K be MAX_ITEMS rounded up to a power of two and L = log2(K). After the
// item that closes a set of n values, the engine pads K-n leaves and plays the
// full tree over the single tree RAM read port. Each further result takes an
// emit step, a step that clears the winning leaf and a replay of its path
// through L levels to the root, one RAM access per level. Items of the next
// set are taken into a two-entry queue while a sort runs, and loaded once the
// engine has emitted the last result.
// Reset clears the counters, the queue and the state; tree contents need no
// reset since every node is written before it is read. A stalled receiver
// holds the result register and the engine waits in its emit step; nothing
// is dropped.
module tournament_tree_sorter_top #(
	parameter int MAX_ITEMS = tts_pkg::DEF_MAX_ITEMS
) (
	input logic       clk,
	input logic       arst_n,
	tts_in_if.sink    items,
	tts_out_if.source results
);

	logic                push_valid;
	logic                push_ready;
	tts_pkg::tts_entry_t push_entry;
	logic                pop_valid;
	logic                pop_ready;
	tts_pkg::tts_entry_t pop_entry;

	tts_front #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	tts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	tts_back #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.results   (results)
	);

endmodule
